### design/ffha_pkg.sv
// shared constants and types for the first-fit heap allocator
package ffha_pkg;
  localparam int HeapBytes   = 16384;
  localparam int HeaderBytes = 24;
  localparam int OffW        = $clog2(HeapBytes);
  localparam int SizeW       = OffW;
  localparam int WalkW       = OffW + 2;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_NO_MEMORY = 2'd1;
  localparam logic [1:0] ST_RELEASED  = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  typedef struct packed {
    logic load;
    logic init_step;
    logic rd_at;
    logic rd_nx;
    logic set_at;
    logic advance;
    logic do_split;
    logic do_alloc;
    logic do_merge;
    logic do_free;
  } ffha_cmd_t;

  typedef struct packed {
    logic init_done;
    logic is_release;
    logic fits;
    logic nx_out;
    logic exact;
    logic splittable;
    logic rel_ok;
    logic both_free;
  } ffha_sts_t;
endpackage

### design/ffha_datapath.sv
// header memory, start map and walk arithmetic
module ffha_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ffha_pkg::ffha_cmd_t  cmd,
  input  logic                 in_command,
  input  logic [13:0]          in_request_bytes,
  input  logic [13:0]          in_release_address,
  output ffha_pkg::ffha_sts_t  sts,
  output logic [13:0]          res_address
);
  import ffha_pkg::*;

  // entry: {free, size}
  logic [SizeW:0]   hdr_mem [HeapBytes];
  logic             map_mem [HeapBytes];
  logic [OffW-1:0]  init_r, at_r, wa, mwa, nb_off;
  logic             cmd_r;
  logic [13:0]      req_r, rel_r;
  logic [SizeW:0]   rd_at_r, rd_nx_r, wd;
  logic             map_rd_r, we, mwe, mwd;
  logic [WalkW-1:0] nx_full, rel_off, nb_full;
  logic [SizeW:0]   merged;

  assign nx_full = WalkW'(at_r) + WalkW'(HeaderBytes) + WalkW'(rd_at_r[SizeW-1:0]);
  assign rel_off = WalkW'(rel_r) - WalkW'(HeaderBytes);
  assign nb_full = WalkW'(at_r) + WalkW'(HeaderBytes) + WalkW'(req_r);
  assign nb_off  = nb_full[OffW-1:0];
  assign merged  = (SizeW+1)'(rd_at_r[SizeW-1:0]) + (SizeW+1)'(rd_nx_r[SizeW-1:0])
                 + (SizeW+1)'(HeaderBytes);

  always_comb begin
    we = 1'b0; wa = at_r; wd = rd_at_r; mwe = 1'b0; mwa = at_r; mwd = 1'b0;
    if (cmd.init_step) begin
      we = 1'b1; wa = init_r; mwe = 1'b1; mwa = init_r;
      mwd = (init_r == '0);
      wd = (init_r == '0) ? {1'b1, SizeW'(HeapBytes - HeaderBytes)} : '0;
    end else if (cmd.do_alloc) begin
      we = 1'b1; wd = {1'b0, rd_at_r[SizeW-1:0]};
    end else if (cmd.do_split) begin
      we = 1'b1; wa = nb_off; mwe = 1'b1; mwa = nb_off; mwd = 1'b1;
      wd = {1'b1, SizeW'(WalkW'(rd_at_r[SizeW-1:0]) - WalkW'(req_r) - WalkW'(HeaderBytes))};
    end else if (cmd.do_merge) begin
      // the absorbed block no longer starts anywhere
      we = 1'b1; wd = {1'b1, merged[SizeW-1:0]};
      mwe = 1'b1; mwa = nx_full[OffW-1:0]; mwd = 1'b0;
    end else if (cmd.do_free) begin
      we = 1'b1; wd = {1'b1, rd_at_r[SizeW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (we) hdr_mem[wa] <= wd;
    if (mwe) map_mem[mwa] <= mwd;
    if (cmd.rd_at) begin
      rd_at_r  <= hdr_mem[at_r];
      map_rd_r <= map_mem[at_r];
    end
    if (cmd.rd_nx) rd_nx_r <= hdr_mem[nx_full[OffW-1:0]];
    // the absorbed header stays in memory but is no longer reachable
    if (cmd.do_merge) rd_at_r <= {1'b1, merged[SizeW-1:0]};
    if (cmd.do_split) rd_at_r <= {1'b0, SizeW'(req_r)};
    if (cmd.load) begin
      cmd_r <= in_command; req_r <= in_request_bytes; rel_r <= in_release_address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0; at_r <= '0;
    end else begin
      if (cmd.init_step) init_r <= init_r + 1'b1;
      if (cmd.load) at_r <= '0;
      else if (cmd.set_at) at_r <= rel_off[OffW-1:0];
      else if (cmd.advance) at_r <= nx_full[OffW-1:0];
    end
  end

  assign sts.init_done  = (init_r == OffW'(HeapBytes - 1));
  assign sts.is_release = (cmd_r == CMD_RELEASE);
  assign sts.fits       = rd_at_r[SizeW] && (WalkW'(rd_at_r[SizeW-1:0]) >= WalkW'(req_r));
  assign sts.nx_out     = nx_full >= WalkW'(HeapBytes);
  assign sts.exact      = rd_at_r[SizeW] && (WalkW'(rd_at_r[SizeW-1:0]) == WalkW'(req_r));
  assign sts.splittable = rd_at_r[SizeW] && (WalkW'(rd_at_r[SizeW-1:0]) > nb_full - WalkW'(at_r));
  assign sts.rel_ok     = (WalkW'(rel_r) >= WalkW'(HeaderBytes)) &&
                          (rel_off < WalkW'(HeapBytes)) && map_rd_r;
  assign sts.both_free  = rd_at_r[SizeW] && rd_nx_r[SizeW];
  assign res_address    = 14'(WalkW'(at_r) + WalkW'(HeaderBytes));
endmodule

### design/ffha_ctrl.sv
// controller sequencing init, allocate walk and release merge walk
module ffha_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [13:0]          out_block_address,
  input  logic [13:0]          res_address,
  input  ffha_pkg::ffha_sts_t  sts,
  output ffha_pkg::ffha_cmd_t  cmd
);
  import ffha_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0, S_IDLE = 4'd1, S_ARD = 4'd2, S_AEV = 4'd3,
                         S_RCHK  = 4'd4, S_RCK2 = 4'd5, S_FREE = 4'd6, S_MRD = 4'd7,
                         S_MNX   = 4'd8, S_MEV = 4'd9, S_OUT = 4'd10, S_SPL = 4'd11;

  logic [3:0]  state_r, state_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [13:0] addr_r, addr_nxt;
  logic        ov_r;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_status = status_r;
  assign out_block_address = addr_r;

  always_comb begin
    cmd = '0; state_nxt = state_r; status_nxt = status_r; addr_nxt = addr_r;
    case (state_r)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_done) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1; state_nxt = S_ARD;
      end
      S_ARD: begin
        if (sts.is_release) begin
          cmd.set_at = 1'b1; state_nxt = S_RCHK;
        end else begin
          cmd.rd_at = 1'b1; state_nxt = S_AEV;
        end
      end
      S_AEV: begin
        if (sts.fits || sts.nx_out) begin
          addr_nxt = '0;
          status_nxt = ST_NO_MEMORY;
          state_nxt = S_OUT;
          if (sts.exact) begin
            cmd.do_alloc = 1'b1; status_nxt = ST_ALLOCATED; addr_nxt = res_address;
          end else if (sts.splittable) begin
            cmd.do_split = 1'b1; status_nxt = ST_ALLOCATED; addr_nxt = res_address;
            state_nxt = S_SPL;
          end
        end else begin
          cmd.advance = 1'b1; state_nxt = S_ARD;
        end
      end
      // front part of a split block is written back as used
      S_SPL: begin
        cmd.do_alloc = 1'b1; state_nxt = S_OUT;
      end
      S_RCHK: begin
        cmd.rd_at = 1'b1; state_nxt = S_RCK2;
      end
      S_RCK2: begin
        addr_nxt = '0;
        if (sts.rel_ok) state_nxt = S_FREE;
        else begin
          status_nxt = ST_INVALID; state_nxt = S_OUT;
        end
      end
      S_FREE: begin
        cmd.do_free = 1'b1; cmd.load = 1'b1; state_nxt = S_MRD;
      end
      S_MRD: begin
        cmd.rd_at = 1'b1; state_nxt = S_MNX;
      end
      S_MNX: begin
        if (sts.nx_out) begin
          status_nxt = ST_RELEASED; state_nxt = S_OUT;
        end else begin
          cmd.rd_nx = 1'b1; state_nxt = S_MEV;
        end
      end
      S_MEV: begin
        if (sts.both_free) begin
          cmd.do_merge = 1'b1; state_nxt = S_MNX;
        end else begin
          cmd.advance = 1'b1; state_nxt = S_MRD;
        end
      end
      // hold the result until it is taken
      S_OUT: if (ov_r && !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && !ov_r) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    addr_r   <= addr_nxt;
  end
endmodule

### design/first_fit_heap_allocator_core.sv
// first-fit heap allocator with split on allocate and merge walk on release
// allocate walks the block chain from the start, with a write-back state on a split;
// release checks the address, frees the block, then walks the chain from the start merging
// free neighbours; one request at a time over the single-port header memory; the next
// request is taken the cycle after the result leaves, so the chain walk sets the rate
// reset: a clearing pass writes the header memory and start map, stall held high
module first_fit_heap_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [13:0] in_request_bytes,
  input  logic [13:0] in_release_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [13:0] out_block_address
);
  import ffha_pkg::*;

  ffha_cmd_t   cmd;
  ffha_sts_t   sts;
  logic [13:0] res_address;

  ffha_datapath u_dp (
    .clk, .rst_n, .cmd, .in_command, .in_request_bytes, .in_release_address,
    .sts, .res_address
  );

  ffha_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_status,
    .out_block_address, .res_address, .sts, .cmd
  );
endmodule

### design/ffha_checker.sv
// port-level checks for the allocator core
module ffha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [13:0] out_block_address
);
  import ffha_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ALLOCATED |-> out_block_address == '0)
    else $error("address not zero");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while result pending");
  a_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ALLOCATED |-> out_block_address >= 14'(HeaderBytes))
    else $error("allocated address inside header");
endmodule

bind first_fit_heap_allocator_core ffha_checker u_chk (.*);
